[sv/averaged_hue_to_rgb_led_mapper_macros.svh]
// ----------------------------------------------------------------------------
// Averaged hue to RGB LED mapper: assertion macros
// Shared concurrent assertion forms used by the mapper's modules.
// ----------------------------------------------------------------------------
`ifndef AVERAGED_HUE_TO_RGB_LED_MAPPER_MACROS_SVH
`define AVERAGED_HUE_TO_RGB_LED_MAPPER_MACROS_SVH

// same-cycle implication
`define AHRGB_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define AHRGB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

[sv/ahrgb_pkg.sv]
// ----------------------------------------------------------------------------
// Averaged hue to RGB LED mapper: package
// Widths, color map edges, stage types and the divide-by-full-scale helper.
// ----------------------------------------------------------------------------
package ahrgb_pkg;

   localparam int WINDOW_DEPTH_DEFAULT = 1024;

   localparam int SAMPLE_W  = 12;
   localparam int VALUE_W   = 16;
   localparam int THRESH_W  = 17;
   localparam int RANDOM_W  = 32;
   localparam int PRODUCT_W = 32;

   localparam logic [VALUE_W-1:0]  GREEN_EDGE      = 16'd20160;
   localparam logic [VALUE_W-1:0]  BLUE_EDGE       = 16'd40320;
   localparam logic [VALUE_W-1:0]  RED_EDGE        = 16'd60480;
   localparam logic [VALUE_W-1:0]  WHITE_EDGE      = 16'd63000;
   localparam logic [VALUE_W-1:0]  FULL_SCALE      = 16'd65535;
   localparam logic [1:0]          FADE_GAIN       = 2'd3;
   localparam int                  SAMPLE_SHIFT    = 4;
   localparam logic [3:0]          BRIGHT_OFFSET   = 4'd15;
   localparam logic [THRESH_W-1:0] THRESHOLD_RESET = 17'd600;

   typedef struct packed {
      logic                valid;
      logic [VALUE_W-1:0]  hue_avg;
      logic [VALUE_W-1:0]  bright_avg;
      logic [RANDOM_W-1:0] random_word;
   } avg_stage_type;

   typedef struct packed {
      logic [VALUE_W-1:0]  red_duty;
      logic [VALUE_W-1:0]  green_duty;
      logic [VALUE_W-1:0]  blue_duty;
      logic                power_on;
      logic [RANDOM_W-1:0] random_word;
      logic [VALUE_W-1:0]  average_hue;
      logic [VALUE_W-1:0]  average_brightness;
   } result_type;

   // floor(x / 65535) for a 32-bit x, truncated to 16 bits
   function automatic logic [VALUE_W-1:0] div_full_scale(input logic [PRODUCT_W-1:0] x);
      logic [VALUE_W:0] y;
      logic [VALUE_W:0] t;
      logic             corr;
      logic [VALUE_W:0] q;
      y    = {1'b0, x[31:16]} + {1'b0, x[15:0]};
      t    = {1'b0, y[VALUE_W-1:0]} + {16'd0, y[VALUE_W]};
      corr = (t >= {1'b0, FULL_SCALE});
      q    = {1'b0, x[31:16]} + {16'd0, y[VALUE_W]} + {16'd0, corr};
      return q[VALUE_W-1:0];
   endfunction

endpackage

[sv/ahrgb_req_if.sv]
// ----------------------------------------------------------------------------
// Averaged hue to RGB LED mapper: sample pair channel
// Valid/ready channel carrying one hue and one brightness converter sample.
// ----------------------------------------------------------------------------
interface ahrgb_req_if import ahrgb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] hue_sample;
   logic [SAMPLE_W-1:0] brightness_sample;

   modport source (output valid, output hue_sample, output brightness_sample, input ready);
   modport sink   (input valid, input hue_sample, input brightness_sample, output ready);
endinterface

[sv/ahrgb_rsp_if.sv]
// ----------------------------------------------------------------------------
// Averaged hue to RGB LED mapper: result channel
// Valid/ready channel carrying duty values, flags and window averages.
// ----------------------------------------------------------------------------
interface ahrgb_rsp_if import ahrgb_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [VALUE_W-1:0]  red_duty;
   logic [VALUE_W-1:0]  green_duty;
   logic [VALUE_W-1:0]  blue_duty;
   logic                power_on;
   logic [RANDOM_W-1:0] random_word;
   logic [VALUE_W-1:0]  average_hue;
   logic [VALUE_W-1:0]  average_brightness;

   modport source (output valid, output red_duty, output green_duty, output blue_duty,
                   output power_on, output random_word, output average_hue,
                   output average_brightness, input ready);
   modport sink   (input valid, input red_duty, input green_duty, input blue_duty,
                   input power_on, input random_word, input average_hue,
                   input average_brightness, output ready);
endinterface

[sv/ahrgb_window.sv]
// ----------------------------------------------------------------------------
// Averaged hue to RGB LED mapper: averaging window
// Sample rings with clearing pass, running sums and the random shift word.
// ----------------------------------------------------------------------------
`include "averaged_hue_to_rgb_led_mapper_macros.svh"

module ahrgb_window import ahrgb_pkg::*; #(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                in_valid,
   input  logic [SAMPLE_W-1:0] hue_sample,
   input  logic [SAMPLE_W-1:0] brightness_sample,
   output logic                clear_done,
   output avg_stage_type       avg_out
);

   localparam int DEPTH_W = $clog2(WINDOW_DEPTH);
   localparam int SUM_W   = VALUE_W + DEPTH_W;

   logic [VALUE_W-1:0] hue_ring    [WINDOW_DEPTH];
   logic [VALUE_W-1:0] bright_ring [WINDOW_DEPTH];

   logic [DEPTH_W-1:0]  clear_slot_ff;
   logic                clear_done_ff;
   logic [DEPTH_W-1:0]  slot_ff;

   logic                s0_valid_ff;
   logic [VALUE_W-1:0]  s0_hue_ff;
   logic [VALUE_W-1:0]  s0_bright_ff;
   logic                s0_bit_ff;
   logic [DEPTH_W-1:0]  s0_slot_ff;
   logic [VALUE_W-1:0]  s0_old_hue_ff;
   logic [VALUE_W-1:0]  s0_old_bright_ff;

   logic                s1_valid_ff;
   logic [SUM_W-1:0]    hue_sum_ff;
   logic [SUM_W-1:0]    bright_sum_ff;
   logic [RANDOM_W-1:0] random_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_slot_ff <= '0;
         clear_done_ff <= 1'b0;
         slot_ff       <= '0;
         s0_valid_ff   <= 1'b0;
         s1_valid_ff   <= 1'b0;
         hue_sum_ff    <= '0;
         bright_sum_ff <= '0;
         random_ff     <= '0;
      end else begin
         if (!clear_done_ff) begin
            clear_slot_ff <= clear_slot_ff + 1'b1;
            if (clear_slot_ff == DEPTH_W'(WINDOW_DEPTH - 1)) begin
               clear_done_ff <= 1'b1;
            end
         end
         if (in_valid) begin
            slot_ff <= slot_ff + 1'b1;
         end
         if (advance) begin
            s0_valid_ff <= in_valid;
            s1_valid_ff <= s0_valid_ff;
            if (s0_valid_ff) begin
               hue_sum_ff    <= hue_sum_ff - SUM_W'(s0_old_hue_ff) + SUM_W'(s0_hue_ff);
               bright_sum_ff <= bright_sum_ff - SUM_W'(s0_old_bright_ff)
                                + SUM_W'(s0_bright_ff);
               random_ff     <= {random_ff[RANDOM_W-2:0], s0_bit_ff};
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         s0_hue_ff    <= {hue_sample, {SAMPLE_SHIFT{1'b0}}};
         s0_bright_ff <= {brightness_sample, BRIGHT_OFFSET};
         s0_bit_ff    <= hue_sample[0] ^ brightness_sample[0];
         s0_slot_ff   <= slot_ff;
      end
   end

   // read old entry on accept, write new entry one stage later
   always_ff @(posedge clock) begin
      if (in_valid) begin
         s0_old_hue_ff    <= hue_ring[slot_ff];
         s0_old_bright_ff <= bright_ring[slot_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (!clear_done_ff) begin
         hue_ring[clear_slot_ff]    <= '0;
         bright_ring[clear_slot_ff] <= '0;
      end else if (advance && s0_valid_ff) begin
         hue_ring[s0_slot_ff]    <= s0_hue_ff;
         bright_ring[s0_slot_ff] <= s0_bright_ff;
      end
   end

   assign clear_done          = clear_done_ff;
   assign avg_out.valid       = s1_valid_ff;
   assign avg_out.hue_avg     = hue_sum_ff[SUM_W-1 -: VALUE_W];
   assign avg_out.bright_avg  = bright_sum_ff[SUM_W-1 -: VALUE_W];
   assign avg_out.random_word = random_ff;

   `AHRGB_ASSERT_HOLDS(a_no_item_while_clearing, clock, reset, !clear_done_ff, !in_valid && !s0_valid_ff && !s1_valid_ff, "transaction in flight during ring clear")
   `AHRGB_ASSERT_NEXT(a_slot_steps, clock, reset, in_valid, slot_ff == DEPTH_W'($past(slot_ff) + 1'b1), "write slot did not advance")
   `AHRGB_ASSERT_HOLDS(a_sums_zero_after_clear, clock, reset, $rose(clear_done_ff), hue_sum_ff == '0 && bright_sum_ff == '0, "running sums not zero after clear")

endmodule

[sv/ahrgb_color.sv]
// ----------------------------------------------------------------------------
// Averaged hue to RGB LED mapper: color map
// Piecewise hue map, brightness scaling and power flag, two register stages.
// ----------------------------------------------------------------------------
module ahrgb_color import ahrgb_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic [THRESH_W-1:0] threshold,
   input  avg_stage_type       avg_in,
   output logic                out_valid,
   output result_type          out_result
);

   localparam int CH_RED   = 0;
   localparam int CH_GREEN = 1;
   localparam int CH_BLUE  = 2;
   localparam int CH_COUNT = 3;

   logic [VALUE_W-1:0] amt      [CH_COUNT];
   logic [VALUE_W-1:0] amt3     [CH_COUNT];
   logic               white;
   logic               power;

   logic                s2_valid_ff;
   logic [VALUE_W-1:0]  s2_amt3_ff [CH_COUNT];
   logic                s2_white_ff;
   logic                s2_power_ff;
   logic [VALUE_W-1:0]  s2_hue_ff;
   logic [VALUE_W-1:0]  s2_lum_ff;
   logic [RANDOM_W-1:0] s2_random_ff;

   logic                 s3_valid_ff;
   logic [PRODUCT_W-1:0] s3_prod_ff [CH_COUNT];
   logic                 s3_white_ff;
   logic                 s3_power_ff;
   logic [VALUE_W-1:0]   s3_hue_ff;
   logic [VALUE_W-1:0]   s3_lum_ff;
   logic [RANDOM_W-1:0]  s3_random_ff;

   always_comb begin
      for (int i = 0; i < CH_COUNT; i++) begin
         amt[i] = '0;
      end
      white = 1'b0;
      if (avg_in.hue_avg <= GREEN_EDGE) begin
         amt[CH_RED]   = GREEN_EDGE - avg_in.hue_avg;
         amt[CH_GREEN] = avg_in.hue_avg;
      end else if (avg_in.hue_avg <= BLUE_EDGE) begin
         amt[CH_GREEN] = BLUE_EDGE - avg_in.hue_avg;
         amt[CH_BLUE]  = avg_in.hue_avg - GREEN_EDGE;
      end else if (avg_in.hue_avg <= RED_EDGE) begin
         amt[CH_RED]   = avg_in.hue_avg - BLUE_EDGE;
         amt[CH_BLUE]  = RED_EDGE - avg_in.hue_avg;
      end else if (avg_in.hue_avg <= WHITE_EDGE) begin
         amt[CH_RED]   = GREEN_EDGE;
      end else begin
         white = 1'b1;
      end
      for (int i = 0; i < CH_COUNT; i++) begin
         amt3[i] = VALUE_W'(amt[i] * FADE_GAIN);
      end
      power = ({1'b0, avg_in.hue_avg} + {1'b0, avg_in.bright_avg}) >= threshold;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s2_valid_ff <= avg_in.valid;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < CH_COUNT; i++) begin
            s2_amt3_ff[i] <= amt3[i];
            s3_prod_ff[i] <= {16'd0, s2_amt3_ff[i]} * {16'd0, s2_lum_ff};
         end
         s2_white_ff  <= white;
         s2_power_ff  <= power;
         s2_hue_ff    <= avg_in.hue_avg;
         s2_lum_ff    <= avg_in.bright_avg;
         s2_random_ff <= avg_in.random_word;
         s3_white_ff  <= s2_white_ff;
         s3_power_ff  <= s2_power_ff;
         s3_hue_ff    <= s2_hue_ff;
         s3_lum_ff    <= s2_lum_ff;
         s3_random_ff <= s2_random_ff;
      end
   end

   assign out_valid = s3_valid_ff;

   always_comb begin
      out_result.red_duty           = s3_white_ff ? s3_lum_ff
                                                  : div_full_scale(s3_prod_ff[CH_RED]);
      out_result.green_duty         = s3_white_ff ? s3_lum_ff
                                                  : div_full_scale(s3_prod_ff[CH_GREEN]);
      out_result.blue_duty          = s3_white_ff ? s3_lum_ff
                                                  : div_full_scale(s3_prod_ff[CH_BLUE]);
      out_result.power_on           = s3_power_ff;
      out_result.random_word        = s3_random_ff;
      out_result.average_hue        = s3_hue_ff;
      out_result.average_brightness = s3_lum_ff;
   end

endmodule

[sv/averaged_hue_to_rgb_led_mapper.sv]
// ----------------------------------------------------------------------------
// Averaged hue to RGB LED mapper: top level
// A result passes window stages s0 and s1, color stages s2 and s3, then the rsp register.
// Throughput: one transaction per cycle; the pipeline stalls only on rsp ready.
// Reset: a clearing pass zeroes both sample rings, one entry per cycle, over all
// WINDOW_DEPTH entries; req ready stays low until it ends. Threshold resets to 600.
// ----------------------------------------------------------------------------
`include "averaged_hue_to_rgb_led_mapper_macros.svh"

module averaged_hue_to_rgb_led_mapper import ahrgb_pkg::*; #(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   ahrgb_req_if.sink           req_ch,
   ahrgb_rsp_if.source         rsp_ch,
   input  logic                csr_wr_en,
   input  logic [THRESH_W-1:0] csr_wr_data
);

   logic                advance;
   logic                accept;
   logic                clear_done;
   avg_stage_type       avg_stage;
   logic                color_valid;
   result_type          color_result;

   logic [THRESH_W-1:0] csr_threshold_ff;
   logic                rsp_valid_ff;
   result_type          rsp_data_ff;

   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance && clear_done;
   assign accept       = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_threshold_ff <= THRESHOLD_RESET;
      end else if (csr_wr_en) begin
         csr_threshold_ff <= csr_wr_data;
      end
   end

   ahrgb_window #(
      .WINDOW_DEPTH (WINDOW_DEPTH)
   ) u_window (
      .clock             (clock),
      .reset             (reset),
      .advance           (advance),
      .in_valid          (accept),
      .hue_sample        (req_ch.hue_sample),
      .brightness_sample (req_ch.brightness_sample),
      .clear_done        (clear_done),
      .avg_out           (avg_stage)
   );

   ahrgb_color u_color (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .threshold  (csr_threshold_ff),
      .avg_in     (avg_stage),
      .out_valid  (color_valid),
      .out_result (color_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= color_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff <= color_result;
      end
   end

   assign rsp_ch.valid              = rsp_valid_ff;
   assign rsp_ch.red_duty           = rsp_data_ff.red_duty;
   assign rsp_ch.green_duty         = rsp_data_ff.green_duty;
   assign rsp_ch.blue_duty          = rsp_data_ff.blue_duty;
   assign rsp_ch.power_on           = rsp_data_ff.power_on;
   assign rsp_ch.random_word        = rsp_data_ff.random_word;
   assign rsp_ch.average_hue        = rsp_data_ff.average_hue;
   assign rsp_ch.average_brightness = rsp_data_ff.average_brightness;

   `AHRGB_ASSERT_HOLDS(a_rsp_after_clear, clock, reset, rsp_ch.valid, clear_done, "result transaction before ring clear finished")

endmodule

[test/ahrgb_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Averaged hue to RGB LED mapper: result checker
// Watches the sample pair and result channels and the threshold port, keeps
// its own sample windows, running sums and LSB shift word, predicts each LED
// frame and compares it with the result that leaves the block.
// ----------------------------------------------------------------------------
module ahrgb_checker import ahrgb_pkg::*; #(
   parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   ahrgb_req_if                req_mon,
   ahrgb_rsp_if                rsp_mon,
   input  logic                csr_wr_en,
   input  logic [THRESH_W-1:0] csr_wr_data,
   output int                  mismatch_count,
   output int                  frames_due
);

   localparam int SLOT_W = $clog2(WINDOW_DEPTH);
   localparam int SUM_W  = VALUE_W + SLOT_W;

   localparam logic [VALUE_W-1:0]  EDGE_GREEN       = 16'd20160;
   localparam logic [VALUE_W-1:0]  EDGE_BLUE        = 16'd40320;
   localparam logic [VALUE_W-1:0]  EDGE_RED         = 16'd60480;
   localparam logic [VALUE_W-1:0]  EDGE_WHITE       = 16'd63000;
   localparam longint              DUTY_FULL        = 65535;
   localparam longint              CROSSFADE_GAIN   = 3;
   localparam logic [THRESH_W-1:0] POWER_LEVEL_INIT = 17'd600;
   localparam int                  REPORT_LIMIT     = 10;

   typedef struct packed {
      logic [VALUE_W-1:0]  red;
      logic [VALUE_W-1:0]  green;
      logic [VALUE_W-1:0]  blue;
      logic                power;
      logic [RANDOM_W-1:0] noise;
      logic [VALUE_W-1:0]  hue_avg;
      logic [VALUE_W-1:0]  bright_avg;
   } led_frame_t;

   logic [VALUE_W-1:0]  hue_hist    [WINDOW_DEPTH];
   logic [VALUE_W-1:0]  bright_hist [WINDOW_DEPTH];
   logic [SLOT_W-1:0]   slot;
   logic [SUM_W-1:0]    hue_total;
   logic [SUM_W-1:0]    bright_total;
   logic [RANDOM_W-1:0] lsb_shift;
   logic [THRESH_W-1:0] power_level;
   led_frame_t          frames_q [$];

   function automatic logic [VALUE_W-1:0] crossfade(input logic [VALUE_W-1:0] amount,
                                                    input logic [VALUE_W-1:0] lum);
      longint product;
      product = longint'(amount) * CROSSFADE_GAIN * longint'(lum);
      return VALUE_W'(product / DUTY_FULL);
   endfunction

   // folds one sample pair into the windows and returns the frame it yields
   function automatic led_frame_t absorb_pair(input logic [SAMPLE_W-1:0] hs,
                                              input logic [SAMPLE_W-1:0] bs);
      logic [VALUE_W-1:0] hv;
      logic [VALUE_W-1:0] bv;
      logic [VALUE_W-1:0] h;
      logic [VALUE_W-1:0] lum;
      led_frame_t         f;
      hv = {hs, 4'h0};
      bv = {bs, 4'hF};
      hue_total    = hue_total - SUM_W'(hue_hist[slot]) + SUM_W'(hv);
      bright_total = bright_total - SUM_W'(bright_hist[slot]) + SUM_W'(bv);
      hue_hist[slot]    = hv;
      bright_hist[slot] = bv;
      slot = (int'(slot) == WINDOW_DEPTH - 1) ? '0 : slot + 1'b1;
      lsb_shift = {lsb_shift[RANDOM_W-2:0], hs[0] ^ bs[0]};
      h   = VALUE_W'(hue_total / WINDOW_DEPTH);
      lum = VALUE_W'(bright_total / WINDOW_DEPTH);
      f = '0;
      if (h <= EDGE_GREEN) begin
         f.red   = crossfade(EDGE_GREEN - h, lum);
         f.green = crossfade(h, lum);
      end else if (h <= EDGE_BLUE) begin
         f.green = crossfade(EDGE_BLUE - h, lum);
         f.blue  = crossfade(h - EDGE_GREEN, lum);
      end else if (h <= EDGE_RED) begin
         f.red  = crossfade(h - EDGE_BLUE, lum);
         f.blue = crossfade(EDGE_RED - h, lum);
      end else if (h <= EDGE_WHITE) begin
         f.red = crossfade(EDGE_GREEN, lum);
      end else begin
         f.red   = lum;
         f.green = lum;
         f.blue  = lum;
      end
      f.power      = ((THRESH_W + 1)'(h) + (THRESH_W + 1)'(lum)) >= (THRESH_W + 1)'(power_level);
      f.noise      = lsb_shift;
      f.hue_avg    = h;
      f.bright_avg = lum;
      return f;
   endfunction

   task automatic log_failure(input string what, input led_frame_t want,
                              input led_frame_t seen);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display("%0t %s: exp r=%0d g=%0d b=%0d pwr=%0b rnd=%h h=%0d l=%0d | got r=%0d g=%0d b=%0d pwr=%0b rnd=%h h=%0d l=%0d",
                  $time, what, want.red, want.green, want.blue, want.power, want.noise,
                  want.hue_avg, want.bright_avg, seen.red, seen.green, seen.blue, seen.power,
                  seen.noise, seen.hue_avg, seen.bright_avg);
   endtask

   always @(posedge clock) begin
      led_frame_t seen;
      led_frame_t want;
      if (reset) begin
         for (int i = 0; i < WINDOW_DEPTH; i++) begin
            hue_hist[i]    = '0;
            bright_hist[i] = '0;
         end
         slot           = '0;
         hue_total      = '0;
         bright_total   = '0;
         lsb_shift      = '0;
         power_level    = POWER_LEVEL_INIT;
         mismatch_count = 0;
         frames_q.delete();
      end else begin
         if (csr_wr_en)
            power_level = csr_wr_data;
         if (req_mon.valid && req_mon.ready)
            frames_q.push_back(absorb_pair(req_mon.hue_sample, req_mon.brightness_sample));
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.red        = rsp_mon.red_duty;
            seen.green      = rsp_mon.green_duty;
            seen.blue       = rsp_mon.blue_duty;
            seen.power      = rsp_mon.power_on;
            seen.noise      = rsp_mon.random_word;
            seen.hue_avg    = rsp_mon.average_hue;
            seen.bright_avg = rsp_mon.average_brightness;
            if (frames_q.size() == 0) begin
               log_failure("unexpected transaction", '0, seen);
            end else begin
               want = frames_q.pop_front();
               if (seen.red !== want.red || seen.green !== want.green ||
                   seen.blue !== want.blue || seen.power !== want.power ||
                   seen.noise !== want.noise || seen.hue_avg !== want.hue_avg ||
                   seen.bright_avg !== want.bright_avg)
                  log_failure("mismatch", want, seen);
            end
         end
      end
      frames_due <= frames_q.size();
   end

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Averaged hue to RGB LED mapper: testbench top
// Drives sample pairs and threshold writes into the mapper under several
// handshake idling mixes; the checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
   import ahrgb_pkg::*;

   localparam int                  CLOCK_PERIOD     = 20;
   localparam int                  RESET_CYCLES     = 7;
   localparam int                  CYCLE_LIMIT      = 200000;
   localparam int                  PHASE_COUNT      = 4;
   localparam int                  PAIRS_PER_PHASE  = 330;
   localparam int                  CLIMB_PAIRS      = 1150;
   localparam int                  SETTLE_CYCLES    = 12;
   localparam int                  SAMPLE_MAX       = 4095;
   localparam logic [THRESH_W-1:0] THRESH_FLOOR     = '0;
   localparam logic [THRESH_W-1:0] THRESH_CEIL      = '1;

   logic                clock;
   logic                reset;
   logic                csr_wr_en;
   logic [THRESH_W-1:0] csr_wr_data;
   int                  sender_idle_pct;
   int                  receiver_stall_pct;
   int                  cycle_count = 0;
   int                  mismatch_count;
   int                  frames_due;
   int                  pair_index;
   int                  hue_run_left;
   int                  bright_run_left;
   int                  hue_center;
   int                  bright_center;

   ahrgb_req_if req_bus ();
   ahrgb_rsp_if rsp_bus ();

   averaged_hue_to_rgb_led_mapper u_top (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ahrgb_checker u_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (mismatch_count),
      .frames_due     (frames_due)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(99) >= receiver_stall_pct);
   end

   function automatic int clip_sample(input int v);
      return (v < 0) ? 0 : (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
   endfunction

   task automatic send_pair(input logic [SAMPLE_W-1:0] hs, input logic [SAMPLE_W-1:0] bs);
      @(negedge clock);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid             = 1'b1;
      req_bus.hue_sample        = hs;
      req_bus.brightness_sample = bs;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // long near-full-scale hue climb sweeps the average through every band,
   // then hue and brightness hover around random levels in runs
   task automatic random_pair(output logic [SAMPLE_W-1:0] hs, output logic [SAMPLE_W-1:0] bs);
      int v;
      int jitter;
      if (pair_index < CLIMB_PAIRS) begin
         v = ($urandom_range(31) == 0) ? $urandom_range(SAMPLE_MAX) : $urandom_range(4000, SAMPLE_MAX);
      end else begin
         if (hue_run_left == 0) begin
            hue_run_left = $urandom_range(16, 128);
            hue_center   = $urandom_range(SAMPLE_MAX);
         end
         hue_run_left--;
         jitter = $urandom_range(128);
         v = ($urandom_range(7) == 0) ? $urandom_range(SAMPLE_MAX)
                                      : clip_sample(hue_center + jitter - 64);
      end
      hs = SAMPLE_W'(v);
      if (bright_run_left == 0) begin
         bright_run_left = $urandom_range(16, 160);
         bright_center   = $urandom_range(SAMPLE_MAX);
      end
      bright_run_left--;
      jitter = $urandom_range(128);
      v = ($urandom_range(7) == 0) ? $urandom_range(SAMPLE_MAX)
                                   : clip_sample(bright_center + jitter - 64);
      bs = SAMPLE_W'(v);
      pair_index++;
   endtask

   task automatic write_threshold(input logic [THRESH_W-1:0] value);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = value;
      @(negedge clock);
      csr_wr_en   = 1'b0;
   endtask

   task automatic drain;
      @(negedge clock);
      req_bus.valid = 1'b0;
      wait (frames_due == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      logic [SAMPLE_W-1:0] hs;
      logic [SAMPLE_W-1:0] bs;
      reset                     = 1'b1;
      csr_wr_en                 = 1'b0;
      csr_wr_data               = '0;
      req_bus.valid             = 1'b0;
      req_bus.hue_sample        = '0;
      req_bus.brightness_sample = '0;
      rsp_bus.ready             = 1'b0;
      sender_idle_pct           = 0;
      receiver_stall_pct        = 0;
      pair_index                = 0;
      hue_run_left              = 0;
      bright_run_left           = 0;
      hue_center                = 0;
      bright_center             = 0;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // corners, walking ones against their complement, LSB parity cases
      send_pair(12'd0, 12'd0);
      send_pair(12'hFFF, 12'hFFF);
      send_pair(12'd0, 12'hFFF);
      send_pair(12'hFFF, 12'd0);
      for (int k = 0; k < SAMPLE_W; k++)
         send_pair(SAMPLE_W'(1 << k), ~SAMPLE_W'(1 << k));
      send_pair(12'd1, 12'd0);
      send_pair(12'd0, 12'd1);
      send_pair(12'd1, 12'd1);
      send_pair(12'd2048, 12'd2048);
      send_pair(12'hFFF, 12'hFFE);
      send_pair(12'hFFE, 12'hFFF);
      drain();

      for (int p = 0; p < PHASE_COUNT; p++) begin
         case (p)
            0: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 0;
               write_threshold(THRESH_FLOOR);
            end
            1: begin
               sender_idle_pct    = 70;
               receiver_stall_pct = 0;
               write_threshold(THRESH_CEIL);
            end
            2: begin
               sender_idle_pct    = 0;
               receiver_stall_pct = 70;
               write_threshold(THRESH_W'($urandom_range(60000, 131000)));
            end
            default: begin
               sender_idle_pct    = 22;
               receiver_stall_pct = 22;
               write_threshold(THRESH_W'($urandom_range(20000, 110000)));
            end
         endcase
         repeat (PAIRS_PER_PHASE) begin
            random_pair(hs, bs);
            send_pair(hs, bs);
         end
         drain();
      end

      if (mismatch_count == 0 && frames_due == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[sim.f]
+incdir+sv
sv/ahrgb_pkg.sv
sv/ahrgb_req_if.sv
sv/ahrgb_rsp_if.sv
sv/ahrgb_window.sv
sv/ahrgb_color.sv
sv/averaged_hue_to_rgb_led_mapper.sv
test/ahrgb_checker.sv
test/testbench.sv
